FILE: hw/rtl/acx_pkg.sv
// ----------------------------------------------------------------------------
// acx_pkg
// Shared widths, mode codes and control structs of the ambisonic object mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package acx_pkg;

  localparam int MODE_W    = 2;
  localparam int OBJ_W     = 4;
  localparam int CHAN_W    = 2;
  localparam int WEIGHT_W  = 16;
  localparam int SAMPLE_W  = 16;
  localparam int FADE_W    = 13;
  localparam int MIX_W     = 24;
  localparam int SUM_W     = 40;
  localparam int FRAC_W    = 12;
  localparam int NUM_CHAN  = 4;
  localparam int ROW_W     = NUM_CHAN * WEIGHT_W;
  localparam int OBJ_CODES = 2 ** OBJ_W;

  // Q12 unity: a fade at or above this selects the current weight alone
  localparam logic [FADE_W-1:0] ONE_Q12 = FADE_W'(4096);

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd2;

  // Strobes that walk one sample through the lane pipeline
  typedef struct packed {
    logic mul1;
    logic interp;
    logic mul2;
    logic acc;
    logic clr;
  } acx_lane_ctl_t;

  // Access requests to the weight store
  typedef struct packed {
    logic                rd_en;
    logic [OBJ_W-1:0]    rd_row;
    logic                ld_en;
    logic [OBJ_W-1:0]    ld_row;
    logic [CHAN_W-1:0]   ld_lane;
    logic [WEIGHT_W-1:0] ld_data;
    logic                cp_en;
    logic [OBJ_W-1:0]    cp_row;
  } acx_wcmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/acx_in_if.sv
// ----------------------------------------------------------------------------
// acx_in_if
// Input word channel: load, sample and commit items with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface acx_in_if;
  import acx_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [OBJ_W-1:0]           object;
  logic [CHAN_W-1:0]          channel;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [SAMPLE_W-1:0] sample;
  logic [FADE_W-1:0]          fade;
  logic                       last_object;

  modport source (
    output valid, mode, object, channel, weight, sample, fade, last_object,
    input  ready
  );

  modport sink (
    input  valid, mode, object, channel, weight, sample, fade, last_object,
    output ready
  );

endinterface

`default_nettype wire

FILE: hw/rtl/acx_out_if.sv
// ----------------------------------------------------------------------------
// acx_out_if
// Result word channel: four saturated ambisonic mix values with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface acx_out_if;
  import acx_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [MIX_W-1:0] mix_w;
  logic signed [MIX_W-1:0] mix_x;
  logic signed [MIX_W-1:0] mix_y;
  logic signed [MIX_W-1:0] mix_z;

  modport source (
    output valid, mix_w, mix_x, mix_y, mix_z,
    input  ready
  );

  modport sink (
    input  valid, mix_w, mix_x, mix_y, mix_z,
    output ready
  );

endinterface

`default_nettype wire

FILE: hw/rtl/acx_wstore.sv
// ----------------------------------------------------------------------------
// acx_wstore
// Current and previous weight memories, one row of four weights per object,
// with per-row valid bits so that unwritten rows read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module acx_wstore #(
  parameter int ROWS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  acx_pkg::acx_wcmd_t       cmd,
  output logic [acx_pkg::ROW_W-1:0] rd_cur,
  output logic [acx_pkg::ROW_W-1:0] rd_prv
);
  import acx_pkg::*;

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [ROW_W-1:0] cur_mem [ROWS];
  logic [ROW_W-1:0] prv_mem [ROWS];
  logic [ROWS-1:0]  cur_valid_r;
  logic [ROWS-1:0]  prv_valid_r;

  logic [ROW_W-1:0] cur_q_r;
  logic [ROW_W-1:0] prv_q_r;
  logic             cur_v_r;
  logic             prv_v_r;

  logic [AW-1:0]    rd_a;
  logic [AW-1:0]    ld_a;
  logic [AW-1:0]    cp_a;
  logic [ROW_W-1:0] fresh_row;

  assign rd_a = cmd.rd_row[AW-1:0];
  assign ld_a = cmd.ld_row[AW-1:0];
  assign cp_a = cmd.cp_row[AW-1:0];

  // A load into an empty row zeroes the other three weights
  always_comb begin
    fresh_row = '0;
    fresh_row[cmd.ld_lane*WEIGHT_W +: WEIGHT_W] = cmd.ld_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      if (cur_valid_r[ld_a]) begin
        cur_mem[ld_a][cmd.ld_lane*WEIGHT_W +: WEIGHT_W] <= cmd.ld_data;
      end else begin
        cur_mem[ld_a] <= fresh_row;
      end
    end
    if (cmd.cp_en) begin
      prv_mem[cp_a] <= rd_cur;
    end
    if (cmd.rd_en) begin
      cur_q_r <= cur_mem[rd_a];
      prv_q_r <= prv_mem[rd_a];
      cur_v_r <= cur_valid_r[rd_a];
      prv_v_r <= prv_valid_r[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= '0;
      prv_valid_r <= '0;
    end else begin
      if (cmd.ld_en) begin
        cur_valid_r[ld_a] <= 1'b1;
      end
      if (cmd.cp_en) begin
        prv_valid_r[cp_a] <= 1'b1;
      end
    end
  end

  assign rd_cur = cur_v_r ? cur_q_r : '0;
  assign rd_prv = prv_v_r ? prv_q_r : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/acx_lane.sv
// ----------------------------------------------------------------------------
// acx_lane
// One ambisonic channel: crossfade the weight, scale the sample, accumulate
// with saturation, and shape the sum into the 24-bit mix value.
// ----------------------------------------------------------------------------
`default_nettype none

module acx_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  acx_pkg::acx_lane_ctl_t            ctl,
  input  logic signed [acx_pkg::WEIGHT_W-1:0] cur,
  input  logic signed [acx_pkg::WEIGHT_W-1:0] prv,
  input  logic [acx_pkg::FADE_W-1:0]        fade,
  input  logic signed [acx_pkg::SAMPLE_W-1:0] sample,
  output logic signed [acx_pkg::MIX_W-1:0]  mix
);
  import acx_pkg::*;

  localparam int DIFF_W  = WEIGHT_W + 1;
  localparam int PROD1_W = DIFF_W + FADE_W + 1;
  localparam int PROD2_W = WEIGHT_W + SAMPLE_W;
  localparam int SH_W    = SUM_W - FRAC_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [MIX_W-1:0] MIX_MAX = {1'b0, {(MIX_W-1){1'b1}}};
  localparam logic signed [MIX_W-1:0] MIX_MIN = {1'b1, {(MIX_W-1){1'b0}}};

  logic signed [DIFF_W-1:0]   diff;
  logic signed [FADE_W:0]     fade_s;
  logic signed [PROD1_W-1:0]  prod1_r;
  logic signed [WEIGHT_W-1:0] prv_d_r;
  logic signed [WEIGHT_W-1:0] wi_r;
  logic signed [PROD2_W-1:0]  prod2_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [SH_W-1:0]     sum_sh;

  // prev + (cur - prev) * f / 4096, floor; the prev term is exact in Q12
  assign diff   = DIFF_W'(cur) - DIFF_W'(prv);
  assign fade_s = {1'b0, fade};

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      prod1_r <= PROD1_W'(diff) * PROD1_W'(fade_s);
      prv_d_r <= prv;
    end
    if (ctl.interp) begin
      // The result lies between prev and cur, so 16-bit wraparound is exact
      wi_r <= prv_d_r + WEIGHT_W'(prod1_r >>> FRAC_W);
    end
    if (ctl.mul2) begin
      prod2_r <= PROD2_W'(wi_r) * PROD2_W'(sample);
    end
  end

  always_comb begin
    sum_wide = (SUM_W+1)'(sum_r) + (SUM_W+1)'(prod2_r);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_nxt = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.clr) begin
      sum_r <= '0;
    end else if (ctl.acc) begin
      sum_r <= sum_nxt;
    end
  end

  // Floor shift, then saturate to the mix width
  assign sum_sh = SH_W'(sum_r >>> FRAC_W);

  always_comb begin
    if (sum_sh[SH_W-1:MIX_W-1] == {(SH_W-MIX_W+1){sum_sh[SH_W-1]}}) begin
      mix = sum_sh[MIX_W-1:0];
    end else begin
      mix = sum_sh[SH_W-1] ? MIX_MIN : MIX_MAX;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ambisonic_crossfade_object_mixer.sv
// ----------------------------------------------------------------------------
// ambisonic_crossfade_object_mixer
// First-order ambisonic object panner with a crossfade between two weight sets.
// ----------------------------------------------------------------------------
// Each object owns four weights (W, X, Y, Z) in a current and a previous
// memory, one row per object, both reading as zero after reset through
// per-row valid bits, so no clearing pass is needed. A load word writes one
// current weight. A sample word reads both rows, crossfades previous toward
// current by the fade (clamped to unity), multiplies by the sample and
// accumulates into four saturating 40-bit sums, through the memory read, the
// crossfade multiply, the interpolation, the sample multiply and the
// accumulate, each in its own register stage, before the next word is taken.
// A sample word marked last then goes through an emit step that shapes the
// sums into the output register, waiting there only while an earlier result
// is still untaken; the output register lets the next word enter while the
// result waits. A commit word copies every current row to previous by a
// sweep through the memory. Objects at or above MAX_OBJECTS touch no weight
// and add nothing; mode 3 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module ambisonic_crossfade_object_mixer #(
  parameter int MAX_OBJECTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  acx_in_if.sink    in_chan,
  acx_out_if.source out_chan
);
  import acx_pkg::*;

  // Only 2**OBJ_W objects are addressable, so the store never needs more rows
  localparam int ROWS = (MAX_OBJECTS < OBJ_CODES) ? MAX_OBJECTS : OBJ_CODES;
  localparam int CW   = $clog2(ROWS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_INTERP,
    ST_MUL2,
    ST_ACC,
    ST_EMIT,
    ST_COPY
  } st_t;

  st_t                        state_r;
  logic [CW-1:0]              cnt_r;
  logic [FADE_W-1:0]          fade_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       last_r;
  logic                       out_valid_r;
  logic signed [MIX_W-1:0]    mix_r [NUM_CHAN];

  logic                       in_fire;
  logic                       in_range;
  logic [FADE_W-1:0]          fade_clamped;
  logic                       emit_go;
  logic                       copy_rd;

  acx_wcmd_t                  wcmd;
  acx_lane_ctl_t              lane_ctl;
  logic [ROW_W-1:0]           rd_cur;
  logic [ROW_W-1:0]           rd_prv;
  logic signed [MIX_W-1:0]    lane_mix [NUM_CHAN];

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Objects past the configured count are dropped but still honor the last mark
  assign in_range = (MAX_OBJECTS >= OBJ_CODES) ||
                    (in_chan.object < OBJ_W'(MAX_OBJECTS));

  assign fade_clamped = (in_chan.fade > ONE_Q12) ? ONE_Q12 : in_chan.fade;

  // Free the output register when it is empty or being taken this cycle
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);

  assign copy_rd = (state_r == ST_COPY) && (cnt_r < CW'(ROWS));

  // Weight store requests: sample reads, loads and the commit sweep
  always_comb begin
    wcmd.rd_en   = (in_fire && (in_chan.mode == MODE_SAMPLE) && in_range) || copy_rd;
    wcmd.rd_row  = (state_r == ST_COPY) ? OBJ_W'(cnt_r) : in_chan.object;
    wcmd.ld_en   = in_fire && (in_chan.mode == MODE_LOAD) && in_range;
    wcmd.ld_row  = in_chan.object;
    wcmd.ld_lane = in_chan.channel;
    wcmd.ld_data = in_chan.weight;
    // Write back the row read in the previous sweep cycle
    wcmd.cp_en   = (state_r == ST_COPY) && (cnt_r != '0);
    wcmd.cp_row  = OBJ_W'(cnt_r - 1'b1);
  end

  always_comb begin
    lane_ctl.mul1   = (state_r == ST_MUL1);
    lane_ctl.interp = (state_r == ST_INTERP);
    lane_ctl.mul2   = (state_r == ST_MUL2);
    lane_ctl.acc    = (state_r == ST_ACC);
    lane_ctl.clr    = emit_go;
  end

  acx_wstore #(
    .ROWS (ROWS)
  ) u_wstore (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (wcmd),
    .rd_cur (rd_cur),
    .rd_prv (rd_prv)
  );

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    acx_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .cur    (rd_cur[c*WEIGHT_W +: WEIGHT_W]),
      .prv    (rd_prv[c*WEIGHT_W +: WEIGHT_W]),
      .fade   (fade_r),
      .sample (sample_r),
      .mix    (lane_mix[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Hold the result until taken; load a fresh one from the emit step
      out_valid_r <= emit_go || (out_valid_r && !out_chan.ready);
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            fade_r   <= fade_clamped;
            sample_r <= in_chan.sample;
            last_r   <= in_chan.last_object;
            if (in_chan.mode == MODE_SAMPLE) begin
              if (in_range) begin
                state_r <= ST_MUL1;
              end else if (in_chan.last_object) begin
                state_r <= ST_EMIT;
              end
            end else if (in_chan.mode == MODE_COMMIT) begin
              cnt_r   <= '0;
              state_r <= ST_COPY;
            end
          end
        end
        ST_MUL1: begin
          state_r <= ST_INTERP;
        end
        ST_INTERP: begin
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          state_r <= last_r ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (emit_go) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
              mix_r[c] <= lane_mix[c];
            end
            state_r <= ST_IDLE;
          end
        end
        ST_COPY: begin
          if (cnt_r == CW'(ROWS)) begin
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.mix_w = mix_r[0];
  assign out_chan.mix_x = mix_r[1];
  assign out_chan.mix_y = mix_r[2];
  assign out_chan.mix_z = mix_r[3];

`ifndef SYNTHESIS
  // A result appears only from the emit step
  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(state_r == ST_EMIT))
    else $error("result word raised outside the emit step");

  // The commit sweep never runs past the last row
  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> (cnt_r <= CW'(ROWS)))
    else $error("commit sweep counter out of range");

  // Every copy write follows the read of its row
  a_copy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    wcmd.cp_en |-> $past(wcmd.rd_en))
    else $error("copy write without preceding store read");

  // Accumulation follows the sample multiply
  a_acc_order: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctl.acc |-> $past(lane_ctl.mul2))
    else $error("accumulate without preceding multiply");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_ambisonic_crossfade_object_mixer.sv
// ----------------------------------------------------------------------------
// tb_ambisonic_crossfade_object_mixer
// Self-checking bench for the ambisonic crossfade object mixer.
// ----------------------------------------------------------------------------
// A queue of pending words feeds a valid/ready driver on the input channel.
// Every accepted word also goes through a local model of the mixer: the two
// weight stores, the crossfade, the four saturating sums and the output
// scaling. The model queues one expected mix for each sample word that
// carries the last mark. The monitor compares every taken result word with
// the oldest expected mix, field by field. Both channels idle in random
// bursts, except in the tail of the run. A watchdog ends a stuck run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ambisonic_crossfade_object_mixer;
  import acx_pkg::*;

  localparam int N_OBJECTS    = 16;
  localparam int STORE_DEPTH  = N_OBJECTS * NUM_CHAN;
  localparam int RANDOM_WORDS = 2000;
  localparam int QUIET_TAIL   = 150;    // pending words left when idling stops
  localparam int DRAIN_CYCLES = 40;     // covers a commit sweep and the output stage
  localparam int STUCK_LIMIT  = 1000;   // cycles with no word moving on either side

  // Mode code that the block ignores
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint MIX_HI = (64'sd1 <<< (MIX_W - 1)) - 1;
  localparam longint MIX_LO = -MIX_HI - 1;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [OBJ_W-1:0]           object;
    logic [CHAN_W-1:0]          channel;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [SAMPLE_W-1:0] sample;
    logic [FADE_W-1:0]          fade;
    logic                       last;
  } mixer_word_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] w;
    logic signed [MIX_W-1:0] x;
    logic signed [MIX_W-1:0] y;
    logic signed [MIX_W-1:0] z;
  } mix_word_t;

  logic clk;
  logic rst_n;

  acx_in_if  in_chan ();
  acx_out_if out_chan ();

  ambisonic_crossfade_object_mixer #(
    .MAX_OBJECTS (N_OBJECTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Model state: both weight stores and the running channel sums
  logic signed [WEIGHT_W-1:0] cur_weight  [STORE_DEPTH] = '{default: '0};
  logic signed [WEIGHT_W-1:0] prev_weight [STORE_DEPTH] = '{default: '0};
  logic signed [SUM_W-1:0]    mix_sum     [NUM_CHAN]    = '{default: '0};

  mixer_word_t word_q[$];        // words still to be driven
  mix_word_t   mix_expect_q[$];  // mixes predicted but not yet seen

  int  total_words    = 0;
  int  words_accepted = 0;
  int  mismatch_count = 0;
  int  idle_cycles    = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  bit  word_taken     = 1'b0;
  bit  quiet_tail     = 1'b0;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model helpers
  // --------------------------------------------------------------------------
  function automatic longint clamp_range(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the model by one accepted word; queue the mix it emits, if any
  task automatic mixer_apply(input mixer_word_t wd);
    longint fq;
    longint cur;
    longint prv;
    longint blend;
    longint acc;
    int row;
    logic signed [MIX_W-1:0] lane [NUM_CHAN];
    mix_word_t res;
    // Clamp the fade to unity
    fq  = (wd.fade > ONE_Q12) ? longint'(ONE_Q12) : longint'(wd.fade);
    row = int'(wd.object) * NUM_CHAN;
    case (wd.mode)
      MODE_LOAD: begin
        if (wd.object < N_OBJECTS) cur_weight[row + int'(wd.channel)] = wd.weight;
      end
      MODE_COMMIT: begin
        prev_weight = cur_weight;
      end
      MODE_SAMPLE: begin
        // Objects beyond the configured count add nothing but may still emit
        if (wd.object < N_OBJECTS) begin
          for (int c = 0; c < NUM_CHAN; c++) begin
            cur   = longint'(cur_weight[row + c]);
            prv   = longint'(prev_weight[row + c]);
            blend = (cur * fq + prv * (longint'(ONE_Q12) - fq)) >>> FRAC_W;
            acc   = longint'(mix_sum[c]) + blend * longint'(wd.sample);
            acc   = clamp_range(acc, SUM_LO, SUM_HI);
            mix_sum[c] = acc[SUM_W-1:0];
          end
        end
        if (wd.last) begin
          for (int c = 0; c < NUM_CHAN; c++) begin
            acc = clamp_range(longint'(mix_sum[c]) >>> FRAC_W, MIX_LO, MIX_HI);
            lane[c]    = acc[MIX_W-1:0];
            mix_sum[c] = '0;
          end
          res.w = lane[0];
          res.x = lane[1];
          res.y = lane[2];
          res.z = lane[3];
          mix_expect_q.push_back(res);
        end
      end
      default: ;  // unused mode: no effect
    endcase
  endtask

  function automatic void check_mix(string name, logic signed [MIX_W-1:0] want,
                                    logic signed [MIX_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_word(logic [MODE_W-1:0] mode, int obj, int chan,
                                     int wt, int smp, int fade, bit last);
    mixer_word_t wd;
    wd.mode    = mode;
    wd.object  = obj[OBJ_W-1:0];
    wd.channel = chan[CHAN_W-1:0];
    wd.weight  = wt[WEIGHT_W-1:0];
    wd.sample  = smp[SAMPLE_W-1:0];
    wd.fade    = fade[FADE_W-1:0];
    wd.last    = last;
    word_q.push_back(wd);
    total_words++;
  endfunction

  // 16-bit signed value, biased toward the two extremes
  function automatic int pick_16();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  // Fade biased toward the ends of the range, sometimes beyond unity
  function automatic int pick_fade();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 4096;
      2:       return $urandom_range(4097, 8191);
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present pending words at the falling edge, hold each until taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    mixer_word_t wd;
    if (rst_n) begin
      if (in_chan.valid && !word_taken) begin
        // hold the current word
      end else if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        wd = word_q.pop_front();
        in_chan.mode        <= wd.mode;
        in_chan.object      <= wd.object;
        in_chan.channel     <= wd.channel;
        in_chan.weight      <= wd.weight;
        in_chan.sample      <= wd.sample;
        in_chan.fade        <= wd.fade;
        in_chan.last_object <= wd.last;
        in_chan.valid       <= 1'b1;
        // drop valid for a burst after this word
        if (!quiet_tail && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 8);
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Result side: stall ready in random bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on accepted input words, check taken result words
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    mixer_word_t seen;
    mix_word_t   want;
    if (!rst_n) begin
      word_taken  <= 1'b0;
      idle_cycles = 0;
    end else begin
      word_taken <= in_chan.valid && in_chan.ready;
      quiet_tail <= word_q.size() < QUIET_TAIL;

      if (in_chan.valid && in_chan.ready) begin
        seen.mode    = in_chan.mode;
        seen.object  = in_chan.object;
        seen.channel = in_chan.channel;
        seen.weight  = in_chan.weight;
        seen.sample  = in_chan.sample;
        seen.fade    = in_chan.fade;
        seen.last    = in_chan.last_object;
        mixer_apply(seen);
        words_accepted++;
      end

      if (out_chan.valid && out_chan.ready) begin
        if (mix_expect_q.size() == 0) begin
          $error("result word with no expected mix waiting: w=%0d x=%0d y=%0d z=%0d",
                 out_chan.mix_w, out_chan.mix_x, out_chan.mix_y, out_chan.mix_z);
          mismatch_count++;
        end else begin
          want = mix_expect_q.pop_front();
          check_mix("mix_w", want.w, out_chan.mix_w);
          check_mix("mix_x", want.x, out_chan.mix_x);
          check_mix("mix_y", want.y, out_chan.mix_y);
          check_mix("mix_z", want.z, out_chan.mix_z);
        end
      end

      // Watchdog: advance while nothing moves, clear on any handshake
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STUCK_LIMIT) begin
        $error("no word moved for %0d cycles, %0d mixes outstanding",
               STUCK_LIMIT, mix_expect_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int n_random;
    int n_obj;
    int fade;
    int obj;
    int smp;
    bit ordered;
    bit sat_done;

    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.mode         = MODE_LOAD;
    in_chan.object       = '0;
    in_chan.channel      = '0;
    in_chan.weight       = '0;
    in_chan.sample       = '0;
    in_chan.fade         = '0;
    in_chan.last_object  = 1'b0;
    out_chan.ready       = 1'b0;

    // Directed: a mix from the cleared stores, extreme weights on the first
    // and last object, fades at zero, unity and beyond, the last mark on a
    // load, a commit and the unused mode
    queue_word(MODE_SAMPLE, 3, 0, 0, 12345, 2000, 1'b1);
    queue_word(MODE_LOAD, 0, 0, 32767, 0, 0, 1'b0);
    queue_word(MODE_LOAD, 0, 1, -32768, 0, 0, 1'b0);
    queue_word(MODE_LOAD, 0, 2, 4096, 0, 0, 1'b0);
    queue_word(MODE_LOAD, 0, 3, -1, 0, 0, 1'b0);
    queue_word(MODE_LOAD, 15, 0, -32768, 0, 0, 1'b0);
    queue_word(MODE_LOAD, 15, 1, 32767, 0, 0, 1'b1);
    queue_word(MODE_LOAD, 15, 2, -4096, 0, 0, 1'b0);
    queue_word(MODE_LOAD, 15, 3, 1, 0, 0, 1'b0);
    queue_word(MODE_SAMPLE, 0, 0, 0, -32768, 0, 1'b0);
    queue_word(MODE_SAMPLE, 15, 0, 0, 32767, 4096, 1'b1);
    queue_word(MODE_COMMIT, 0, 0, 0, 0, 0, 1'b1);
    queue_word(MODE_LOAD, 0, 0, -32768, 0, 0, 1'b0);
    queue_word(MODE_SAMPLE, 0, 3, 0, 32767, 8191, 1'b0);
    queue_word(MODE_SAMPLE, 0, 0, 0, -32768, 2048, 1'b0);
    queue_word(MODE_UNUSED, 15, 3, -1, -1, 8191, 1'b1);
    queue_word(MODE_SAMPLE, 15, 0, 0, 1, 4097, 1'b1);
    queue_word(MODE_SAMPLE, 7, 0, 0, -1, 1, 1'b1);

    // Random: mostly well-formed frames (weight loads, maybe a commit, then
    // one sample per object with the last mark on the final one), some noise
    n_random = 0;
    sat_done = 1'b0;
    while (n_random < RANDOM_WORDS) begin
      if (!sat_done && n_random >= 400) begin
        // Drive the sums into saturation: one object with full-scale weights
        // in both stores; first a short frame that clips the output, then a
        // long one that clips the 40-bit sums and walks back into range
        sat_done = 1'b1;
        obj = $urandom_range(0, N_OBJECTS - 1);
        queue_word(MODE_LOAD, obj, 0, -32768, 0, 0, 1'b0);
        queue_word(MODE_LOAD, obj, 1, -32768, 0, 0, 1'b0);
        queue_word(MODE_LOAD, obj, 2, 32767, 0, 0, 1'b0);
        queue_word(MODE_LOAD, obj, 3, 32767, 0, 0, 1'b0);
        queue_word(MODE_COMMIT, 0, 0, 0, 0, 0, 1'b0);
        repeat (40) queue_word(MODE_SAMPLE, obj, 0, 0, -32768, pick_fade(), 1'b0);
        queue_word(MODE_SAMPLE, obj, 0, 0, -32768, pick_fade(), 1'b1);
        repeat (520) queue_word(MODE_SAMPLE, obj, 0, 0, -32768, pick_fade(), 1'b0);
        repeat (500) queue_word(MODE_SAMPLE, obj, 0, 0, 32767, pick_fade(), 1'b0);
        queue_word(MODE_SAMPLE, obj, 0, 0, 0, pick_fade(), 1'b1);
        n_random += 1067;
      end else if ($urandom_range(0, 9) == 0) begin
        // Noise: ignored mode, stray last marks, broken frames
        case ($urandom_range(0, 3))
          0: queue_word(MODE_UNUSED, $urandom_range(0, 15), $urandom_range(0, 3),
                        pick_16(), pick_16(), $urandom_range(0, 8191),
                        1'($urandom_range(0, 1)));
          1: queue_word(MODE_LOAD, $urandom_range(0, 15), $urandom_range(0, 3),
                        pick_16(), pick_16(), $urandom_range(0, 8191), 1'b1);
          2: queue_word(MODE_COMMIT, $urandom_range(0, 15), $urandom_range(0, 3),
                        pick_16(), pick_16(), $urandom_range(0, 8191), 1'b1);
          default: queue_word(MODE_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 3),
                              pick_16(), pick_16(), $urandom_range(0, 8191),
                              1'($urandom_range(0, 1)));
        endcase
        n_random++;
      end else begin
        repeat ($urandom_range(0, 6)) begin
          queue_word(MODE_LOAD, $urandom_range(0, 15), $urandom_range(0, 3),
                     pick_16(), pick_16(), $urandom_range(0, 8191), 1'b0);
          n_random++;
        end
        if ($urandom_range(0, 3) == 0) begin
          queue_word(MODE_COMMIT, 0, 0, 0, 0, 0, 1'b0);
          n_random++;
        end
        n_obj   = $urandom_range(1, N_OBJECTS);
        fade    = pick_fade();
        ordered = 1'($urandom_range(0, 1));
        for (int k = 0; k < n_obj; k++) begin
          obj = ordered ? k : $urandom_range(0, 15);
          smp = pick_16();
          queue_word(MODE_SAMPLE, obj, $urandom_range(0, 3), pick_16(), smp,
                     ($urandom_range(0, 3) == 0) ? pick_fade() : fade, k == n_obj - 1);
          n_random++;
        end
      end
    end

    // Hold reset, then release it away from the sampling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for every word to be taken and every mix to arrive, then drain
    while (words_accepted < total_words) @(negedge clk);
    while (mix_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && mix_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
